### hdl/efsd_pkg.sv
// ----------------------------------------------------------------------------
// efsd_pkg
// Shared types and constants for the earliest free server dispatcher.
// ----------------------------------------------------------------------------
package efsd_pkg;

    localparam int ARR_W  = 17;   // arrival second of day
    localparam int MIN_W  = 10;   // service length in minutes
    localparam int SC_W   = 8;    // server count register
    localparam int TIME_W = 32;   // free times and wait sums
    localparam int CNT_W  = 24;   // accepted job counter
    localparam int IDX_W  = 7;    // reported server index
    localparam int SVC_W  = 16;   // service length in seconds

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [SC_W-1:0]  RST_SERVER_COUNT = SC_W'(1);
    localparam logic [ARR_W-1:0] RST_OPEN_TIME    = ARR_W'(8 * 60 * 60);
    localparam logic [ARR_W-1:0] RST_CLOSE_TIME   = ARR_W'(17 * 60 * 60);
    localparam logic [MIN_W-1:0] RST_SERVICE_CAP  = MIN_W'(60);
    localparam logic [5:0]       SEC_PER_MIN      = 6'd60;
    localparam logic [CNT_W-1:0] CNT_MAX          = {CNT_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_MAX        = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        REG_SERVER_COUNT = 2'd0,
        REG_OPEN_TIME    = 2'd1,
        REG_CLOSE_TIME   = 2'd2,
        REG_SERVICE_CAP  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [SC_W-1:0]  server_count;
        logic [ARR_W-1:0] open_time;
        logic [ARR_W-1:0] close_time;
        logic [MIN_W-1:0] service_cap;
    } t_cfg;

    typedef struct packed {
        logic              accepted;
        logic [CNT_W-1:0]  accepted_count;
        logic [TIME_W-1:0] total_wait_seconds;
        logic [TIME_W-1:0] wait_seconds;
        logic [IDX_W-1:0]  server_index;
    } t_result;

endpackage

### hdl/efsd_ram.sv
// ----------------------------------------------------------------------------
// efsd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module efsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/efsd_cfg.sv
// ----------------------------------------------------------------------------
// efsd_cfg
// APB register file holding the dispatcher configuration.
// ----------------------------------------------------------------------------
module efsd_cfg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [efsd_pkg::APB_AW-1:0] paddr,
    input  logic [efsd_pkg::APB_DW-1:0] pwdata,
    output logic [efsd_pkg::APB_DW-1:0] prdata,
    output logic                     pready,
    output efsd_pkg::t_cfg           o_cfg,
    output logic                     o_reload
);
    import efsd_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.server_count <= RST_SERVER_COUNT;
            r_cfg.open_time    <= RST_OPEN_TIME;
            r_cfg.close_time   <= RST_CLOSE_TIME;
            r_cfg.service_cap  <= RST_SERVICE_CAP;
        end else if (w_wr) begin
            case (w_idx)
                REG_SERVER_COUNT: r_cfg.server_count <= pwdata[SC_W-1:0];
                REG_OPEN_TIME:    r_cfg.open_time    <= pwdata[ARR_W-1:0];
                REG_CLOSE_TIME:   r_cfg.close_time   <= pwdata[ARR_W-1:0];
                REG_SERVICE_CAP:  r_cfg.service_cap  <= pwdata[MIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_SERVER_COUNT: prdata = APB_DW'(r_cfg.server_count);
            REG_OPEN_TIME:    prdata = APB_DW'(r_cfg.open_time);
            REG_CLOSE_TIME:   prdata = APB_DW'(r_cfg.close_time);
            REG_SERVICE_CAP:  prdata = APB_DW'(r_cfg.service_cap);
            default:          prdata = '0;
        endcase
    end

    // Writing the open time restarts the free time table.
    assign o_reload = w_wr && (w_idx == REG_OPEN_TIME);
    assign o_cfg    = r_cfg;

endmodule

### hdl/efsd_core.sv
// ----------------------------------------------------------------------------
// efsd_core
// Sequencer that scans the free time table through one comparator, updates
// the chosen server and keeps the running totals.
// ----------------------------------------------------------------------------
module efsd_core #(
    parameter int MAX_SERVERS = 128,
    localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  efsd_pkg::t_cfg                i_cfg,
    input  logic                          i_reload,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [efsd_pkg::ARR_W-1:0]    i_arrival,
    input  logic [efsd_pkg::MIN_W-1:0]    i_minutes,
    output logic                          o_res_valid,
    input  logic                          i_res_take,
    output efsd_pkg::t_result             o_res,
    output logic                          o_ram_we,
    output logic [AW-1:0]                 o_ram_waddr,
    output logic [efsd_pkg::TIME_W-1:0]   o_ram_wdata,
    output logic [AW-1:0]                 o_ram_raddr,
    input  logic [efsd_pkg::TIME_W-1:0]   i_ram_rdata
);
    import efsd_pkg::*;

    localparam int CW = $clog2(MAX_SERVERS + 1);
    localparam int XW = (CW > SC_W) ? CW : SC_W;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_CALC  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state            r_state;
    logic [AW-1:0]     r_clr_addr;
    logic [ARR_W-1:0]  r_arrival;
    logic [MIN_W-1:0]  r_minutes;
    logic              r_reject;
    logic [AW-1:0]     r_last_idx;
    logic [AW-1:0]     r_rd_addr;
    logic              r_rd_done;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_idx;
    logic [TIME_W-1:0] r_best;
    logic [AW-1:0]     r_best_idx;
    logic [TIME_W-1:0] r_wait;
    logic [TIME_W-1:0] r_sum;
    logic [CNT_W-1:0]  r_cnt;

    logic [XW-1:0]     w_sc;
    logic [XW-1:0]     w_active;
    logic              w_accept;
    logic              w_issue;
    logic [SVC_W-1:0]  w_service;
    logic              w_busy;
    logic [TIME_W-1:0] w_wait;
    logic [TIME_W:0]   w_ext_sum;
    logic [TIME_W-1:0] w_new_free;
    logic [TIME_W:0]   w_wsum;
    logic [TIME_W-1:0] n_sum;
    logic [CNT_W-1:0]  n_cnt;

    // Servers in use: zero counts as one, anything above the table depth clips.
    always_comb begin
        w_sc = XW'(i_cfg.server_count);
        if (w_sc == '0) begin
            w_active = XW'(1);
        end else if (w_sc > XW'(MAX_SERVERS)) begin
            w_active = XW'(MAX_SERVERS);
        end else begin
            w_active = w_sc;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = o_in_ready && i_in_valid;
    assign w_issue    = (r_state == S_SCAN) && !r_rd_done;
    assign w_service  = SVC_W'(r_minutes) * SVC_W'(SEC_PER_MIN);

    // Update arithmetic for the chosen server.
    assign w_busy    = (r_best >= TIME_W'(r_arrival));
    assign w_wait    = w_busy ? (r_best - TIME_W'(r_arrival)) : '0;
    assign w_ext_sum = {1'b0, r_best} + (TIME_W + 1)'(w_service);
    always_comb begin
        if (w_busy) begin
            w_new_free = w_ext_sum[TIME_W] ? TIME_MAX : w_ext_sum[TIME_W-1:0];
        end else begin
            w_new_free = TIME_W'(r_arrival) + TIME_W'(w_service);
        end
    end

    // Totals as they stand after this job.
    assign w_wsum = {1'b0, r_sum} + {1'b0, r_wait};
    always_comb begin
        if (r_reject) begin
            n_sum = r_sum;
            n_cnt = r_cnt;
        end else begin
            n_sum = w_wsum[TIME_W] ? TIME_MAX : w_wsum[TIME_W-1:0];
            n_cnt = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + CNT_W'(1);
        end
    end

    // Table write port: clearing sweep or the single update of a job.
    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = r_best_idx;
        o_ram_wdata = w_new_free;
        case (r_state)
            S_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_clr_addr;
                o_ram_wdata = TIME_W'(i_cfg.open_time);
            end
            S_CALC: begin
                o_ram_we = 1'b1;
            end
            default: ;
        endcase
    end
    assign o_ram_raddr = r_rd_addr;

    assign o_res_valid               = (r_state == S_DONE);
    assign o_res.accepted            = !r_reject;
    assign o_res.accepted_count      = n_cnt;
    assign o_res.total_wait_seconds  = n_sum;
    assign o_res.wait_seconds        = r_reject ? '0 : r_wait;
    assign o_res.server_index        = r_reject ? '0 : IDX_W'(r_best_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_rd_done  <= 1'b1;
            r_rd_vld   <= 1'b0;
            r_sum      <= '0;
            r_cnt      <= '0;
        end else begin
            r_rd_vld <= w_issue;
            r_rd_idx <= r_rd_addr;
            if (w_issue) begin
                r_rd_done <= (r_rd_addr == r_last_idx);
                r_rd_addr <= r_rd_addr + AW'(1);
            end
            if (r_rd_vld && ((r_rd_idx == '0) || (i_ram_rdata < r_best))) begin
                r_best     <= i_ram_rdata;
                r_best_idx <= r_rd_idx;
            end

            if (i_reload) begin
                r_state    <= S_CLEAR;
                r_clr_addr <= '0;
            end else begin
                case (r_state)
                    S_CLEAR: begin
                        r_clr_addr <= r_clr_addr + AW'(1);
                        if (r_clr_addr == AW'(MAX_SERVERS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (w_accept) begin
                            r_arrival  <= i_arrival;
                            r_minutes  <= (i_minutes > i_cfg.service_cap) ?
                                          i_cfg.service_cap : i_minutes;
                            r_reject   <= (i_arrival > i_cfg.close_time);
                            r_last_idx <= AW'(w_active - XW'(1));
                            r_rd_addr  <= '0;
                            r_rd_done  <= 1'b0;
                            r_best_idx <= '0;
                            r_state    <= (i_arrival > i_cfg.close_time) ? S_DONE : S_SCAN;
                        end
                    end
                    S_SCAN: begin
                        if (r_rd_vld && (r_rd_idx == r_last_idx)) begin
                            r_state <= S_CALC;
                        end
                    end
                    S_CALC: begin
                        r_wait  <= w_wait;
                        r_state <= S_DONE;
                    end
                    S_DONE: begin
                        if (i_res_take) begin
                            r_sum   <= n_sum;
                            r_cnt   <= n_cnt;
                            r_state <= S_IDLE;
                        end
                    end
                    default: r_state <= S_CLEAR;
                endcase
            end
        end
    end

endmodule

### hdl/earliest_free_server_dispatch.sv
// ----------------------------------------------------------------------------
// earliest_free_server_dispatch
// Dispatches each job to the server that frees up earliest and reports the
// wait, the running wait total and the accepted job count.
// ----------------------------------------------------------------------------
//
//  Port group   Direction  Beat contents
//  s_axis       in         tdata: arrival_second[16:0], service_minutes[26:17]
//  m_axis       out        tdata: server_index, wait, total wait, count
//                          tuser: accepted
//  APB          in/out     server_count, open_time, close_time, service cap
//
// For an accepted job the free time table is read one entry per cycle, over
// the N servers in use (server_count, zero taken as one, clipped at
// MAX_SERVERS), through a single read port and folded through one shared
// comparator; the chosen entry is then updated and the result is handed to
// the output register. A job arriving after the close time skips the scan.
// After reset, and after every write of open_time, a sweep writes open_time
// into all MAX_SERVERS table entries; no input beat is taken meanwhile.
// A stalled output register holds the finished result and stops the
// sequencer only when the next result is ready to be handed over.
// ----------------------------------------------------------------------------
module earliest_free_server_dispatch #(
    parameter int MAX_SERVERS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input beat, tdata from bit 0: arrival_second (17), service_minutes (10)
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,
    // Result beat, tdata from bit 0: server_index (7), wait_seconds (32),
    // total_wait_seconds (32), accepted_count (24)
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [95:0]                   m_axis_tdata,
    // tuser: accepted (1)
    output logic                          m_axis_tuser,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [efsd_pkg::APB_AW-1:0]   paddr,
    input  logic [efsd_pkg::APB_DW-1:0]   pwdata,
    output logic [efsd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import efsd_pkg::*;

    localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

    t_cfg              w_cfg;
    logic              w_reload;
    logic              w_res_valid;
    logic              w_res_take;
    t_result           w_res;
    logic              w_ram_we;
    logic [AW-1:0]     w_ram_waddr;
    logic [TIME_W-1:0] w_ram_wdata;
    logic [AW-1:0]     w_ram_raddr;
    logic [TIME_W-1:0] w_ram_rdata;

    logic              r_out_valid;
    t_result           r_out;

    efsd_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (w_cfg),
        .o_reload (w_reload)
    );

    // Free time table, one 32-bit entry per server.
    efsd_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_SERVERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    efsd_core #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_reload    (w_reload),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_arrival   (s_axis_tdata[16:0]),
        .i_minutes   (s_axis_tdata[26:17]),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_res_take),
        .o_res       (w_res),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    // Output register: a new result moves in when the register is empty or
    // its beat completes in the same cycle.
    assign w_res_take = w_res_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.accepted;
    assign m_axis_tdata  = {1'b0, r_out.accepted_count, r_out.total_wait_seconds,
                            r_out.wait_seconds, r_out.server_index};

    // The sequencer works on one job at a time.
    a_one_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input beat taken while a job is in progress");

    // The output register only fills from a result handed over by the core.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_res_take))
        else $error("result beat appeared without a handover");

    // A rejected job carries no server and no wait.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
        (r_out.server_index == '0) && (r_out.wait_seconds == '0))
        else $error("rejected job reports a server or a wait");

endmodule
